@@ design/cjpr_pkg.sv @@
package cjpr_pkg;

   localparam int MAX_PACKAGE_DEFAULT = 512;

   // Input operation codes.
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_BYTE    = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Done status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_ACK    = 2'd1;
   localparam logic [1:0] ST_NO_DATA   = 2'd2;
   localparam logic [1:0] ST_TOO_MANY  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_PICTURE_TYPE  = 2'd0;
   localparam logic [1:0] REG_PACKAGE_BYTES = 2'd1;
   localparam logic [1:0] REG_ERROR_LIMIT   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [7:0] PICTURE_TYPE_RESET  = 8'd5;
   localparam logic [9:0] PACKAGE_BYTES_RESET = 10'd128;
   localparam logic [3:0] ERROR_LIMIT_RESET   = 4'd5;

   // Protocol bytes.
   localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
   localparam logic [7:0]  CMD_ACK       = 8'h0E;
   localparam logic [7:0]  CMD_GET_PIC   = 8'h04;
   localparam logic [15:0] FINAL_ACK_ID  = 16'hF0F0;
   localparam int          FRAME_OVERHEAD = 6;
   localparam int          HEADER_BYTES   = 4;
   localparam int          MIN_PACKAGE    = 8;

   // Positions of the result sequencer.
   localparam logic [2:0] POS_DATA = 3'd0;
   localparam logic [2:0] POS_ACK0 = 3'd1;
   localparam logic [2:0] POS_ACK5 = 3'd6;
   localparam logic [2:0] POS_DONE = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ACK  = 3'd1,
      PH_DATA = 3'd2,
      PH_PKG  = 3'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [23:0] offset;
      logic [1:0]  status;
      logic [23:0] total_size;
      logic        last;
   } rsp_type;

   // Everything one input item causes: an optional data byte, an optional
   // six-byte command, and an optional done result, emitted in that order.
   typedef struct packed {
      logic            has_data;
      logic [7:0]      data_byte;
      logic [23:0]     data_offset;
      logic            has_ack;
      logic [5:0][7:0] ack_bytes;
      logic            has_done;
      logic [1:0]      done_status;
      logic [23:0]     done_offset;
      logic [23:0]     done_total;
   } desc_type;

   function automatic logic [5:0][7:0] pkg_ack(input logic [15:0] id);
      logic [5:0][7:0] b;
      b[0] = SYNC_BYTE;
      b[1] = CMD_ACK;
      b[2] = 8'd0;
      b[3] = 8'd0;
      b[4] = id[7:0];
      b[5] = id[15:8];
      return b;
   endfunction

endpackage

@@ design/cjpr_ctrl.sv @@
module cjpr_ctrl #(
   parameter int MAX_PACKAGE = cjpr_pkg::MAX_PACKAGE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic              fire,
   input  cjpr_pkg::req_type req,
   output logic              desc_load,
   output cjpr_pkg::desc_type desc
);

   localparam int PW = $clog2(MAX_PACKAGE + 1);

   logic [7:0] picture_type_ff;
   logic [9:0] package_bytes_ff;
   logic [3:0] error_limit_ff;

   cjpr_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0] fi_ff, fi_in;
   logic [7:0]    r1_ff, r1_in, r2_ff, r2_in;
   logic [15:0]   dl_ff, dl_in;
   logic [23:0]   pic_ff, pic_in;
   logic [23:0]   base_ff, base_in;
   logic [15:0]   pc_ff, pc_in;
   logic [3:0]    ec_ff, ec_in;

   logic [PW-1:0] eff_pkg, frag, pl, fi_plus;
   logic [23:0]   rem, base_next, pic_next;
   logic [15:0]   fr6;
   logic [3:0]    lim, ec_plus;
   logic          in_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         picture_type_ff  <= cjpr_pkg::PICTURE_TYPE_RESET;
         package_bytes_ff <= cjpr_pkg::PACKAGE_BYTES_RESET;
         error_limit_ff   <= cjpr_pkg::ERROR_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            cjpr_pkg::REG_PICTURE_TYPE:  picture_type_ff  <= csr_data[7:0];
            cjpr_pkg::REG_PACKAGE_BYTES: package_bytes_ff <= csr_data[9:0];
            cjpr_pkg::REG_ERROR_LIMIT:   error_limit_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Fragment geometry of the current package.
   always_comb begin
      if (package_bytes_ff < 10'(cjpr_pkg::MIN_PACKAGE)) begin
         eff_pkg = PW'(cjpr_pkg::MIN_PACKAGE);
      end else if (24'(package_bytes_ff) > 24'(MAX_PACKAGE)) begin
         eff_pkg = PW'(MAX_PACKAGE);
      end else begin
         eff_pkg = PW'(package_bytes_ff);
      end
      rem = pic_ff - base_ff;
      if (24'(eff_pkg) - 24'(cjpr_pkg::FRAME_OVERHEAD) > rem) begin
         frag = PW'(rem + 24'(cjpr_pkg::FRAME_OVERHEAD));
      end else begin
         frag = eff_pkg;
      end
      fr6 = 16'(frag) - 16'(cjpr_pkg::FRAME_OVERHEAD);
      pl  = (dl_ff > fr6) ? PW'(fr6) : PW'(dl_ff);
      fi_plus    = fi_ff + PW'(1);
      in_payload = (fi_ff >= PW'(cjpr_pkg::HEADER_BYTES)) &&
                   ((PW+1)'(fi_ff) < (PW+1)'(pl) + (PW+1)'(cjpr_pkg::HEADER_BYTES));
      base_next  = base_ff + 24'(pl);
      lim        = (error_limit_ff == 4'd0) ? 4'd1 : error_limit_ff;
      ec_plus    = ec_ff + 4'd1;
      pic_next   = pic_ff;
      unique case (fi_ff)
         PW'(3):  pic_next = {pic_ff[23:8], req.rx_byte};
         PW'(4):  pic_next = {pic_ff[23:16], req.rx_byte, pic_ff[7:0]};
         PW'(5):  pic_next = {req.rx_byte, pic_ff[15:0]};
         default: ;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      fi_in    = fi_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      dl_in    = dl_ff;
      pic_in   = pic_ff;
      base_in  = base_ff;
      pc_in    = pc_ff;
      ec_in    = ec_ff;
      desc     = '0;
      if (fire) begin
         unique case (req.op)
            cjpr_pkg::OP_START: begin
               phase_in = cjpr_pkg::PH_ACK;
               fi_in    = '0;
               r1_in    = '0;
               r2_in    = '0;
               dl_in    = '0;
               pic_in   = '0;
               base_in  = '0;
               pc_in    = '0;
               ec_in    = '0;
               desc.has_ack   = 1'b1;
               desc.ack_bytes = {8'd0, 8'd0, 8'd0, picture_type_ff,
                                 cjpr_pkg::CMD_GET_PIC, cjpr_pkg::SYNC_BYTE};
            end
            cjpr_pkg::OP_BYTE: begin
               unique case (phase_ff)
                  cjpr_pkg::PH_ACK: begin
                     if (fi_ff == PW'(1)) r1_in = req.rx_byte;
                     if (fi_ff == PW'(2)) r2_in = req.rx_byte;
                     if (fi_ff == PW'(5)) begin
                        fi_in = '0;
                        if (r1_ff == cjpr_pkg::CMD_ACK && r2_ff == cjpr_pkg::CMD_GET_PIC) begin
                           phase_in = cjpr_pkg::PH_DATA;
                        end else begin
                           phase_in         = cjpr_pkg::PH_IDLE;
                           desc.has_done    = 1'b1;
                           desc.done_status = cjpr_pkg::ST_NO_ACK;
                           desc.done_offset = base_ff;
                           desc.done_total  = pic_ff;
                        end
                     end else begin
                        fi_in = fi_plus;
                     end
                  end
                  cjpr_pkg::PH_DATA: begin
                     pic_in = pic_next;
                     if (fi_ff == PW'(5)) begin
                        fi_in = '0;
                        if (pic_next == 24'd0) begin
                           phase_in         = cjpr_pkg::PH_IDLE;
                           desc.has_ack     = 1'b1;
                           desc.ack_bytes   = cjpr_pkg::pkg_ack(cjpr_pkg::FINAL_ACK_ID);
                           desc.has_done    = 1'b1;
                           desc.done_status = cjpr_pkg::ST_OK;
                           desc.done_offset = base_ff;
                           desc.done_total  = pic_next;
                        end else begin
                           phase_in       = cjpr_pkg::PH_PKG;
                           desc.has_ack   = 1'b1;
                           desc.ack_bytes = cjpr_pkg::pkg_ack(pc_ff);
                        end
                     end else begin
                        fi_in = fi_plus;
                     end
                  end
                  cjpr_pkg::PH_PKG: begin
                     if (fi_ff == PW'(2)) dl_in = {dl_ff[15:8], req.rx_byte};
                     if (fi_ff == PW'(3)) dl_in = {req.rx_byte, dl_ff[7:0]};
                     if (in_payload) begin
                        desc.has_data    = 1'b1;
                        desc.data_byte   = req.rx_byte;
                        desc.data_offset = base_ff + 24'(fi_ff) -
                                           24'(cjpr_pkg::HEADER_BYTES);
                     end
                     if (fi_plus >= frag) begin
                        // Package complete: advance the picture offset and id.
                        base_in = base_next;
                        pc_in   = pc_ff + 16'd1;
                        ec_in   = '0;
                        fi_in   = '0;
                        desc.has_ack = 1'b1;
                        if (base_next >= pic_ff) begin
                           phase_in         = cjpr_pkg::PH_IDLE;
                           desc.ack_bytes   = cjpr_pkg::pkg_ack(cjpr_pkg::FINAL_ACK_ID);
                           desc.has_done    = 1'b1;
                           desc.done_status = cjpr_pkg::ST_OK;
                           desc.done_offset = base_next;
                           desc.done_total  = pic_ff;
                        end else begin
                           desc.ack_bytes = cjpr_pkg::pkg_ack(pc_ff + 16'd1);
                        end
                     end else begin
                        fi_in = fi_plus;
                     end
                  end
                  default: ;
               endcase
            end
            cjpr_pkg::OP_TIMEOUT: begin
               unique case (phase_ff)
                  cjpr_pkg::PH_ACK, cjpr_pkg::PH_DATA: begin
                     phase_in         = cjpr_pkg::PH_IDLE;
                     fi_in            = '0;
                     desc.has_done    = 1'b1;
                     desc.done_status = (phase_ff == cjpr_pkg::PH_ACK) ?
                                        cjpr_pkg::ST_NO_ACK : cjpr_pkg::ST_NO_DATA;
                     desc.done_offset = base_ff;
                     desc.done_total  = pic_ff;
                  end
                  cjpr_pkg::PH_PKG: begin
                     ec_in        = ec_plus;
                     fi_in        = '0;
                     desc.has_ack = 1'b1;
                     if (ec_plus >= lim) begin
                        phase_in         = cjpr_pkg::PH_IDLE;
                        desc.ack_bytes   = cjpr_pkg::pkg_ack(cjpr_pkg::FINAL_ACK_ID);
                        desc.has_done    = 1'b1;
                        desc.done_status = cjpr_pkg::ST_TOO_MANY;
                        desc.done_offset = base_ff;
                        desc.done_total  = pic_ff;
                     end else begin
                        desc.ack_bytes = cjpr_pkg::pkg_ack(pc_ff);
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   assign desc_load = fire && (desc.has_data || desc.has_ack || desc.has_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cjpr_pkg::PH_IDLE;
         fi_ff    <= '0;
         r1_ff    <= '0;
         r2_ff    <= '0;
         dl_ff    <= '0;
         pic_ff   <= '0;
         base_ff  <= '0;
         pc_ff    <= '0;
         ec_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         fi_ff    <= fi_in;
         r1_ff    <= r1_in;
         r2_ff    <= r2_in;
         dl_ff    <= dl_in;
         pic_ff   <= pic_in;
         base_ff  <= base_in;
         pc_ff    <= pc_in;
         ec_ff    <= ec_in;
      end
   end

endmodule

@@ design/cjpr_emit.sv @@
module cjpr_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_load,
   input  cjpr_pkg::desc_type desc,
   output logic               slot_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cjpr_pkg::rsp_type  rsp_payload
);

   cjpr_pkg::desc_type desc_ff;
   logic               busy_ff;
   logic [2:0]         pos_ff, pos_in, next_pos, first_pos;
   logic               has_next, taken;
   logic [2:0]         ack_idx;

   always_comb begin
      if (desc.has_data) begin
         first_pos = cjpr_pkg::POS_DATA;
      end else if (desc.has_ack) begin
         first_pos = cjpr_pkg::POS_ACK0;
      end else begin
         first_pos = cjpr_pkg::POS_DONE;
      end
   end

   always_comb begin
      next_pos = cjpr_pkg::POS_DONE;
      has_next = 1'b0;
      priority if (pos_ff == cjpr_pkg::POS_DONE) begin
         has_next = 1'b0;
      end else if (pos_ff == cjpr_pkg::POS_DATA) begin
         has_next = desc_ff.has_ack || desc_ff.has_done;
         next_pos = desc_ff.has_ack ? cjpr_pkg::POS_ACK0 : cjpr_pkg::POS_DONE;
      end else if (pos_ff == cjpr_pkg::POS_ACK5) begin
         has_next = desc_ff.has_done;
      end else begin
         has_next = 1'b1;
         next_pos = pos_ff + 3'd1;
      end
   end

   assign taken     = busy_ff && !rsp_stall;
   assign slot_free = !busy_ff || (taken && !has_next);
   assign rsp_valid = busy_ff;

   always_comb begin
      pos_in = pos_ff;
      if (desc_load) begin
         pos_in = first_pos;
      end else if (taken && has_next) begin
         pos_in = next_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (desc_load) begin
         busy_ff <= 1'b1;
      end else if (taken && !has_next) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (desc_load) begin
         desc_ff <= desc;
      end
   end

   assign ack_idx = pos_ff - cjpr_pkg::POS_ACK0;

   always_comb begin
      rsp_payload      = '0;
      rsp_payload.last = !has_next;
      priority if (pos_ff == cjpr_pkg::POS_DATA) begin
         rsp_payload.kind       = cjpr_pkg::KIND_DATA;
         rsp_payload.byte_value = desc_ff.data_byte;
         rsp_payload.offset     = desc_ff.data_offset;
      end else if (pos_ff == cjpr_pkg::POS_DONE) begin
         rsp_payload.kind       = cjpr_pkg::KIND_DONE;
         rsp_payload.offset     = desc_ff.done_offset;
         rsp_payload.status     = desc_ff.done_status;
         rsp_payload.total_size = desc_ff.done_total;
      end else begin
         rsp_payload.kind       = cjpr_pkg::KIND_TX;
         rsp_payload.byte_value = desc_ff.ack_bytes[ack_idx];
      end
   end

endmodule

@@ design/camera_jpeg_package_receiver_unit.sv @@
// Serial camera JPEG package receiver.
// The req channel carries one beat per event: a start request, a byte that
// came in from the camera, or a response timeout. The rsp channel carries the
// beats that each event causes, in order: bytes to transmit to the camera,
// picture data bytes with their picture offsets, and a done beat with the
// status and picture size. The final beat of an event carries last.
// The csr channel writes picture type, package length and error limit; it is
// always ready, and the user must write it only while the block is idle; the
// block itself does not enforce this. A req beat is processed in the cycle
// it is accepted; its first rsp beat is valid in the next cycle, and while
// rsp_stall is low one rsp beat follows per cycle after that, up to seven
// beats for one event. The next req beat is taken in the cycle the last
// rsp beat of the previous event is taken, so a byte event with one result
// sustains one beat per cycle while rsp_stall is low.
// Events that produce no results are absorbed with no rsp beat.
// Synchronous reset returns the protocol to idle, clears all counters and
// restores the register defaults. While rsp_stall is high the current rsp
// beat holds, and req_stall rises once an event's results are waiting.
module camera_jpeg_package_receiver_unit #(
   parameter int MAX_PACKAGE = cjpr_pkg::MAX_PACKAGE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cjpr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cjpr_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic               fire;
   logic               slot_free;
   logic               desc_load;
   cjpr_pkg::desc_type desc;

   // The result slot must be free, or freeing this cycle, before a new event
   // may update the protocol state.
   assign req_stall = !slot_free;
   assign fire      = req_valid && slot_free;
   assign csr_ready = 1'b1;

   cjpr_ctrl #(
      .MAX_PACKAGE(MAX_PACKAGE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fire      (fire),
      .req       (req_payload),
      .desc_load (desc_load),
      .desc      (desc)
   );

   // Serializes the results of one event onto the rsp channel.
   cjpr_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .desc_load   (desc_load),
      .desc        (desc),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
